[hdl/prlc_pkg.sv]
// ---------------------------------------------------------------------------
// prlc_pkg
// Shared constants, register and command codes, configuration record and
// width helpers for the rate-limited PID controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prlc_pkg;

   // default sample width (error, pilot, drive, history)
   localparam int SAMPLE_WIDTH_DEF = 16;

   // fixed field widths
   localparam int GAIN_WIDTH     = 16;
   localparam int ACCUM_WIDTH    = 24;
   localparam int OLIM_WIDTH     = 15;
   localparam int SLIM_WIDTH     = 16;
   localparam int SUMLIM_WIDTH   = 23;
   localparam int CMD_WIDTH      = 2;

   // fraction bits removed after each product
   localparam int FRAC_BITS      = 8;
   localparam int IG_FRAC_BITS   = 12;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_ADDR_WIDTH  = CSR_INDEX_WIDTH + 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KP          = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INT_GAIN    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DER_GAIN    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUT_LIMIT   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STEP_LIMIT  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACCUM_LIMIT = 3'd5;

   // request commands
   localparam logic [CMD_WIDTH-1:0] CMD_TRACK = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_ERROR = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic signed [GAIN_WIDTH-1:0] kp;
      logic signed [GAIN_WIDTH-1:0] integral_gain;
      logic signed [GAIN_WIDTH-1:0] derivative_gain;
      logic [OLIM_WIDTH-1:0]        output_limit;
      logic [SLIM_WIDTH-1:0]        step_limit;
      logic [SUMLIM_WIDTH-1:0]      accum_limit;
   } cfg_type;

   // derivative numerator e + 3e1 - 3e2 - e3
   function automatic int num_width(input int sw);
      return sw + 3;
   endfunction

   // numerator / 6 can exceed the sample range by a third
   function automatic int deriv_width(input int sw);
      return sw + 1;
   endfunction

   // combined term: error + integral term + derivative term
   function automatic int comb_width(input int sw);
      int itw;
      int dtw;
      itw = GAIN_WIDTH + ACCUM_WIDTH - IG_FRAC_BITS;
      dtw = GAIN_WIDTH + deriv_width(sw) - FRAC_BITS;
      return ((itw > dtw) ? itw : dtw) + 2;
   endfunction

endpackage

[hdl/prlc_csr.sv]
// ---------------------------------------------------------------------------
// prlc_csr
// Configuration register file behind an APB-style port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [prlc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [prlc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [prlc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output prlc_pkg::cfg_type                   cfg
);
   import prlc_pkg::*;

   cfg_type                    cfg_ff;
   cfg_type                    cfg_in;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic                       write;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            REG_KP:          cfg_in.kp              = csr_pwdata[GAIN_WIDTH-1:0];
            REG_INT_GAIN:    cfg_in.integral_gain   = csr_pwdata[GAIN_WIDTH-1:0];
            REG_DER_GAIN:    cfg_in.derivative_gain = csr_pwdata[GAIN_WIDTH-1:0];
            REG_OUT_LIMIT:   cfg_in.output_limit    = csr_pwdata[OLIM_WIDTH-1:0];
            REG_STEP_LIMIT:  cfg_in.step_limit      = csr_pwdata[SLIM_WIDTH-1:0];
            REG_ACCUM_LIMIT: cfg_in.accum_limit     = csr_pwdata[SUMLIM_WIDTH-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_KP:          csr_prdata = {{(CSR_DATA_WIDTH-GAIN_WIDTH){1'b0}}, cfg_ff.kp};
         REG_INT_GAIN:    csr_prdata = {{(CSR_DATA_WIDTH-GAIN_WIDTH){1'b0}},
                                        cfg_ff.integral_gain};
         REG_DER_GAIN:    csr_prdata = {{(CSR_DATA_WIDTH-GAIN_WIDTH){1'b0}},
                                        cfg_ff.derivative_gain};
         REG_OUT_LIMIT:   csr_prdata = {{(CSR_DATA_WIDTH-OLIM_WIDTH){1'b0}},
                                        cfg_ff.output_limit};
         REG_STEP_LIMIT:  csr_prdata = {{(CSR_DATA_WIDTH-SLIM_WIDTH){1'b0}},
                                        cfg_ff.step_limit};
         REG_ACCUM_LIMIT: csr_prdata = {{(CSR_DATA_WIDTH-SUMLIM_WIDTH){1'b0}},
                                        cfg_ff.accum_limit};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/prlc_mul.sv]
// ---------------------------------------------------------------------------
// prlc_mul
// Shared signed multiplier, gain times operand, product registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlc_mul #(
   parameter int B_WIDTH = prlc_pkg::comb_width(prlc_pkg::SAMPLE_WIDTH_DEF)
) (
   input  logic                                          clock,
   input  logic signed [prlc_pkg::GAIN_WIDTH-1:0]         mul_a,
   input  logic signed [B_WIDTH-1:0]                      mul_b,
   output logic signed [prlc_pkg::GAIN_WIDTH+B_WIDTH-1:0] mul_p
);
   import prlc_pkg::*;

   logic signed [GAIN_WIDTH+B_WIDTH-1:0] product_ff;
   logic signed [GAIN_WIDTH+B_WIDTH-1:0] product_in;

   assign product_in = mul_a * mul_b;
   assign mul_p      = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

[hdl/prlc_div6.sv]
// ---------------------------------------------------------------------------
// prlc_div6
// Divide by six, truncating toward zero, by multiplying the magnitude with
// a scaled reciprocal. Magnitude and sign are registered on start; the
// quotient is registered in the cycle after that and done rises with it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlc_div6 #(
   parameter int SAMPLE_WIDTH = prlc_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 div_start,
   input  logic signed [prlc_pkg::num_width(SAMPLE_WIDTH)-1:0]   div_num,
   output logic                                                 div_done,
   output logic signed [prlc_pkg::deriv_width(SAMPLE_WIDTH)-1:0] div_quot
);
   import prlc_pkg::*;

   localparam int NW    = num_width(SAMPLE_WIDTH);
   localparam int DW    = deriv_width(SAMPLE_WIDTH);
   // ceil(2^SHIFT / 6) overshoots by at most 5, exact for any NW-bit magnitude
   localparam int SHIFT = NW + 3;
   localparam int RECW  = NW + 1;
   localparam int PRODW = NW + RECW;
   localparam logic [RECW-1:0] RECIP = RECW'(((64'd1 << SHIFT) + 64'd5) / 64'd6);

   logic [NW-1:0]        mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic signed [DW-1:0] quot_ff, quot_in;
   logic [NW-1:0]        magnitude;
   logic [PRODW-1:0]     product;
   logic [DW-1:0]        quot_mag;

   assign magnitude = div_num[NW-1] ? NW'(-div_num) : NW'(div_num);
   // constant multiply, NW by NW + 1 bits
   assign product   = PRODW'(mag_ff) * PRODW'(RECIP);
   assign quot_mag  = product[SHIFT +: DW];
   assign div_quot  = quot_ff;
   assign div_done  = done_ff;

   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      quot_in = quot_ff;
      if (div_start) begin
         mag_in  = magnitude;
         neg_in  = div_num[NW-1];
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quot_in = neg_ff ? $signed(-quot_mag) : $signed(quot_mag);
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

endmodule

[hdl/prlc_core.sv]
// ---------------------------------------------------------------------------
// prlc_core
// Sequencer and datapath: error, history, integral sum, output clamp and
// rate limit, with the output register. Products go through the shared
// multiplier, the derivative through the divide-by-six unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prlc_core #(
   parameter int SAMPLE_WIDTH = prlc_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  prlc_pkg::cfg_type                                        cfg,
   input  logic                                                     req_valid,
   output logic                                                     req_ready,
   input  logic [prlc_pkg::CMD_WIDTH-1:0]                           command,
   input  logic signed [SAMPLE_WIDTH-1:0]                           reference,
   input  logic signed [SAMPLE_WIDTH-1:0]                           measured,
   input  logic signed [SAMPLE_WIDTH-1:0]                           pilot,
   output logic                                                     rsp_valid,
   input  logic                                                     rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]                                  drive,
   output logic signed [prlc_pkg::GAIN_WIDTH-1:0]                   mul_a,
   output logic signed [prlc_pkg::comb_width(SAMPLE_WIDTH)-1:0]     mul_b,
   input  logic signed [prlc_pkg::GAIN_WIDTH+prlc_pkg::comb_width(SAMPLE_WIDTH)-1:0] mul_p,
   output logic                                                     div_start,
   output logic signed [prlc_pkg::num_width(SAMPLE_WIDTH)-1:0]      div_num,
   input  logic                                                     div_done,
   input  logic signed [prlc_pkg::deriv_width(SAMPLE_WIDTH)-1:0]    div_quot
);
   import prlc_pkg::*;

   localparam int W    = SAMPLE_WIDTH;
   localparam int NW   = num_width(W);
   localparam int DW   = deriv_width(W);
   localparam int CW   = comb_width(W);
   localparam int PW   = GAIN_WIDTH + CW;
   localparam int RW   = PW - FRAC_BITS + 1;
   localparam int SUMW = ((ACCUM_WIDTH > W) ? ACCUM_WIDTH : W) + 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_NUM  = 4'd1;
   localparam logic [3:0] S_INT  = 4'd2;
   localparam logic [3:0] S_DIV  = 4'd3;
   localparam logic [3:0] S_DER  = 4'd4;
   localparam logic [3:0] S_KP   = 4'd5;
   localparam logic [3:0] S_OUT  = 4'd6;
   localparam logic [3:0] S_LIM  = 4'd7;
   localparam logic [3:0] S_RATE = 4'd8;
   localparam logic [3:0] S_SAT  = 4'd9;

   localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

   logic [3:0]                    state_ff, state_in;
   logic signed [W-1:0]           e1_ff, e1_in, e2_ff, e2_in, e3_ff, e3_in;
   logic signed [ACCUM_WIDTH-1:0] acc_ff, acc_in;
   logic signed [W-1:0]           last_ff, last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                  drive_ff, drive_in;
   logic signed [W-1:0]           err_ff, err_in;
   logic signed [W-1:0]           pilot_ff, pilot_in;
   logic signed [CW-1:0]          comb_ff, comb_in;
   logic signed [RW-1:0]          ret_ff, ret_in;

   logic                          accept;
   logic                          out_free;
   logic signed [W:0]             diff_track;
   logic signed [W-1:0]           err_track, err_new;
   logic signed [NW-1:0]          e0x, e1x, e2x, e3x;
   logic signed [PW-1:0]          prod_ig, prod_fr;
   logic signed [CW-1:0]          int_term, der_term, err_cx;
   logic signed [RW-1:0]          pilot_rx, olim_rx, last_rx, step_rx, diff_rx;
   logic signed [RW-1:0]          smax_rx, smin_rx;
   logic signed [SUMW-1:0]        sum_x, slim_x;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign drive     = drive_ff;

   // tracking error, saturated to the sample range
   assign diff_track = {reference[W-1], reference} - {measured[W-1], measured};
   assign err_track  = (diff_track[W] != diff_track[W-1]) ?
                       (diff_track[W] ? SMIN : SMAX) : diff_track[W-1:0];
   assign err_new    = (command == CMD_ERROR) ? reference : err_track;

   // derivative numerator
   assign e0x     = {{(NW-W){err_ff[W-1]}}, err_ff};
   assign e1x     = {{(NW-W){e1_ff[W-1]}}, e1_ff};
   assign e2x     = {{(NW-W){e2_ff[W-1]}}, e2_ff};
   assign e3x     = {{(NW-W){e3_ff[W-1]}}, e3_ff};
   assign div_num = e0x + (e1x <<< 1) + e1x - (e2x <<< 1) - e2x - e3x;
   assign div_start = (state_ff == S_NUM);

   // multiplier operand selection; the registered product appears in the following cycle
   always_comb begin
      case (state_ff)
         S_NUM: begin
            mul_a = cfg.integral_gain;
            mul_b = {{(CW-ACCUM_WIDTH){acc_ff[ACCUM_WIDTH-1]}}, acc_ff};
         end
         S_DIV: begin
            mul_a = cfg.derivative_gain;
            mul_b = {{(CW-DW){div_quot[DW-1]}}, div_quot};
         end
         default: begin
            mul_a = cfg.kp;
            mul_b = comb_ff;
         end
      endcase
   end

   assign prod_ig  = mul_p >>> IG_FRAC_BITS;
   assign prod_fr  = mul_p >>> FRAC_BITS;
   assign int_term = prod_ig[CW-1:0];
   assign der_term = prod_fr[CW-1:0];
   assign err_cx   = {{(CW-W){err_ff[W-1]}}, err_ff};

   assign pilot_rx = {{(RW-W){pilot_ff[W-1]}}, pilot_ff};
   assign olim_rx  = $signed({{(RW-OLIM_WIDTH){1'b0}}, cfg.output_limit});
   assign last_rx  = {{(RW-W){last_ff[W-1]}}, last_ff};
   assign step_rx  = $signed({{(RW-SLIM_WIDTH){1'b0}}, cfg.step_limit});
   assign diff_rx  = ret_ff - last_rx;
   assign smax_rx  = {{(RW-W){1'b0}}, SMAX};
   assign smin_rx  = {{(RW-W){1'b1}}, SMIN};

   assign sum_x  = {{(SUMW-ACCUM_WIDTH){acc_ff[ACCUM_WIDTH-1]}}, acc_ff}
                 + {{(SUMW-W){err_ff[W-1]}}, err_ff};
   assign slim_x = $signed({{(SUMW-SUMLIM_WIDTH){1'b0}}, cfg.accum_limit});

   always_comb begin
      state_in     = state_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      e3_in        = e3_ff;
      acc_in       = acc_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      drive_in     = drive_ff;
      err_in       = err_ff;
      pilot_in     = pilot_ff;
      comb_in      = comb_ff;
      ret_in       = ret_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (command)
                  CMD_TRACK, CMD_ERROR: begin
                     err_in   = err_new;
                     pilot_in = pilot;
                     state_in = S_NUM;
                  end
                  CMD_CLEAR: begin
                     // history and sum only; last output is kept
                     e1_in  = '0;
                     e2_in  = '0;
                     e3_in  = '0;
                     acc_in = '0;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_NUM: state_in = S_INT;
         S_INT: begin
            comb_in  = err_cx + int_term;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_DER;
            end
         end
         S_DER: begin
            comb_in  = comb_ff + der_term;
            state_in = S_KP;
         end
         S_KP: state_in = S_OUT;
         S_OUT: begin
            ret_in   = $signed(prod_fr[RW-1:0]) + pilot_rx;
            state_in = S_LIM;
         end
         S_LIM: begin
            if (ret_ff > olim_rx) begin
               ret_in = olim_rx;
            end else if (ret_ff < -olim_rx) begin
               ret_in = -olim_rx;
            end
            state_in = S_RATE;
         end
         S_RATE: begin
            if (diff_rx > step_rx) begin
               ret_in = last_rx + step_rx;
            end else if (diff_rx < -step_rx) begin
               ret_in = last_rx - step_rx;
            end
            state_in = S_SAT;
         end
         S_SAT: begin
            if (out_free) begin
               if (ret_ff > smax_rx) begin
                  last_in = SMAX;
               end else if (ret_ff < smin_rx) begin
                  last_in = SMIN;
               end else begin
                  last_in = ret_ff[W-1:0];
               end
               drive_in     = last_in;
               rsp_valid_in = 1'b1;
               e3_in        = e2_ff;
               e2_in        = e1_ff;
               e1_in        = err_ff;
               if (sum_x > slim_x) begin
                  acc_in = slim_x[ACCUM_WIDTH-1:0];
               end else if (sum_x < -slim_x) begin
                  acc_in = ACCUM_WIDTH'(-slim_x);
               end else begin
                  acc_in = sum_x[ACCUM_WIDTH-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         e1_ff        <= '0;
         e2_ff        <= '0;
         e3_ff        <= '0;
         acc_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         e1_ff        <= e1_in;
         e2_ff        <= e2_in;
         e3_ff        <= e3_in;
         acc_ff       <= acc_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      drive_ff <= drive_in;
      err_ff   <= err_in;
      pilot_ff <= pilot_in;
      comb_ff  <= comb_in;
      ret_ff   <= ret_in;
   end

endmodule

[hdl/pid_rate_limited_controller_top.sv]
// ---------------------------------------------------------------------------
// pid_rate_limited_controller_top
// PID step with feedforward, output clamp and per-sample rate limit.
//
//   channel  dir  handshake             payload
//   req_     in   tvalid/tready         tuser: command; tdata: reference,
//                                       measured, pilot
//   rsp_     out  tvalid/tready         tdata: drive
//   csr_     in   APB psel/penable      six gain and limit registers
//
// A track or direct-error request takes the accept cycle and nine sequencer
// steps, set by the three dependent products on the shared multiplier and
// the limit stages; the divide by six runs beside the integral product.
// Its response is registered in the SAT step when the output is free.
// Clear and unused commands finish in the accept cycle and give no response.
// Synchronous reset clears registers, history, sum and last output.
// A stalled response holds in the output register; the next request is
// taken meanwhile, and a later result waits only for that register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_rate_limited_controller_top #(
   parameter int SAMPLE_WIDTH = prlc_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // requests
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] command
   input  logic [prlc_pkg::CMD_WIDTH-1:0]      req_tuser,
   // reference, measured, pilot (SAMPLE_WIDTH each), zero pad
   input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   // responses
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // drive (SAMPLE_WIDTH), zero pad
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [prlc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [prlc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [prlc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import prlc_pkg::*;

   localparam int W       = SAMPLE_WIDTH;
   localparam int NW      = num_width(W);
   localparam int DW      = deriv_width(W);
   localparam int CW      = comb_width(W);
   localparam int RSP_TDW = ((W + 7) / 8) * 8;

   cfg_type                     cfg;
   logic signed [GAIN_WIDTH-1:0] mul_a;
   logic signed [CW-1:0]         mul_b;
   logic signed [GAIN_WIDTH+CW-1:0] mul_p;
   logic                         div_start;
   logic signed [NW-1:0]         div_num;
   logic                         div_done;
   logic signed [DW-1:0]         div_quot;
   logic [W-1:0]                 drive;

   assign rsp_tdata = RSP_TDW'(drive);

   prlc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   prlc_mul #(
      .B_WIDTH (CW)
   ) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   prlc_div6 #(
      .SAMPLE_WIDTH (W)
   ) u_div6 (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_num   (div_num),
      .div_done  (div_done),
      .div_quot  (div_quot)
   );

   prlc_core #(
      .SAMPLE_WIDTH (W)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .command   (req_tuser),
      .reference (req_tdata[W-1:0]),
      .measured  (req_tdata[2*W-1:W]),
      .pilot     (req_tdata[3*W-1:2*W]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .drive     (drive),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .mul_p     (mul_p),
      .div_start (div_start),
      .div_num   (div_num),
      .div_done  (div_done),
      .div_quot  (div_quot)
   );

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rate-limited PID controller. It drives
// requests with random gaps and holds off responses at random. Every
// accepted request goes through a local model of the control law (error
// history, clamped sum, output clamp and rate limit). Each response is
// compared with the oldest predicted drive. Gains and limits are changed
// over the APB port between phases while the controller is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import prlc_pkg::*;

   localparam int SW = SAMPLE_WIDTH_DEF;
   localparam logic [CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;
   localparam longint DRIVE_MAX = 32767;
   localparam longint DRIVE_MIN = -32768;
   // margin after the last response before touching registers
   localparam int DRAIN_CYCLES = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_REQUESTS = 220;

   logic clock;
   logic reset = 1'b1;

   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [CMD_WIDTH-1:0]           req_tuser = '0;   // [1:0] command
   logic [((3*SW+7)/8)*8-1:0]      req_tdata = '0;   // reference, measured, pilot
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [((SW+7)/8)*8-1:0]        rsp_tdata;        // drive
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0]      csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0]      csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0]      csr_prdata;
   logic                           csr_pready;

   pid_rate_limited_controller_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // controller model state
   cfg_type                 ctl_cfg = '0;
   logic signed [SW-1:0]    err_hist1 = '0;
   logic signed [SW-1:0]    err_hist2 = '0;
   logic signed [SW-1:0]    err_hist3 = '0;
   logic signed [ACCUM_WIDTH-1:0] err_sum = '0;
   logic signed [SW-1:0]    drive_last = '0;

   logic signed [SW-1:0]    expected_drive_q[$];
   int                      mismatch_count = 0;
   bit                      req_no_gap = 1'b0;
   bit                      rsp_no_stall = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
      if (x > hi)
         return hi;
      if (x < lo)
         return lo;
      return x;
   endfunction

   // advance the model by one request; queue the drive it produces
   function automatic void step_controller(input logic [CMD_WIDTH-1:0] cmd,
                                           input logic signed [SW-1:0] setpoint,
                                           input logic signed [SW-1:0] measurement,
                                           input logic signed [SW-1:0] feedforward);
      longint err;
      longint slope;
      longint combined;
      longint drive;
      longint olim;
      longint slim;
      longint sumlim;
      olim   = longint'(ctl_cfg.output_limit);
      slim   = longint'(ctl_cfg.step_limit);
      sumlim = longint'(ctl_cfg.accum_limit);
      if (cmd == CMD_CLEAR) begin
         err_hist1 = '0;
         err_hist2 = '0;
         err_hist3 = '0;
         err_sum   = '0;
         return;
      end
      if (cmd == CMD_UNUSED)
         return;
      if (cmd == CMD_TRACK)
         err = clamp_to(longint'(setpoint) - longint'(measurement), DRIVE_MIN, DRIVE_MAX);
      else
         err = longint'(setpoint);
      // signed divide truncates toward zero
      slope = (err + 3 * longint'(err_hist1) - 3 * longint'(err_hist2)
               - longint'(err_hist3)) / 6;
      combined = err
               + ((longint'($signed(ctl_cfg.integral_gain)) * longint'(err_sum))
                  >>> IG_FRAC_BITS)
               + ((longint'($signed(ctl_cfg.derivative_gain)) * slope) >>> FRAC_BITS);
      drive = ((longint'($signed(ctl_cfg.kp)) * combined) >>> FRAC_BITS)
            + longint'(feedforward);
      drive = clamp_to(drive, -olim, olim);
      if (drive - longint'(drive_last) > slim)
         drive = longint'(drive_last) + slim;
      if (drive - longint'(drive_last) < -slim)
         drive = longint'(drive_last) - slim;
      drive = clamp_to(drive, DRIVE_MIN, DRIVE_MAX);
      drive_last = drive[SW-1:0];
      err_hist3  = err_hist2;
      err_hist2  = err_hist1;
      err_hist1  = err[SW-1:0];
      err_sum    = ACCUM_WIDTH'(clamp_to(longint'(err_sum) + err, -sumlim, sumlim));
      expected_drive_q.push_back(drive[SW-1:0]);
   endfunction

   function automatic logic [CSR_DATA_WIDTH-1:0] reg_mask(input logic [CSR_INDEX_WIDTH-1:0] idx);
      case (idx)
         REG_OUT_LIMIT:   return (32'd1 << OLIM_WIDTH) - 1;
         REG_ACCUM_LIMIT: return (32'd1 << SUMLIM_WIDTH) - 1;
         default:         return (32'd1 << GAIN_WIDTH) - 1;
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_KP:          ctl_cfg.kp              = value[GAIN_WIDTH-1:0];
         REG_INT_GAIN:    ctl_cfg.integral_gain   = value[GAIN_WIDTH-1:0];
         REG_DER_GAIN:    ctl_cfg.derivative_gain = value[GAIN_WIDTH-1:0];
         REG_OUT_LIMIT:   ctl_cfg.output_limit    = value[OLIM_WIDTH-1:0];
         REG_STEP_LIMIT:  ctl_cfg.step_limit      = value[SLIM_WIDTH-1:0];
         REG_ACCUM_LIMIT: ctl_cfg.accum_limit     = value[SUMLIM_WIDTH-1:0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] want);
      logic [CSR_DATA_WIDTH-1:0] mask;
      mask = reg_mask(idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if ((csr_prdata & mask) !== (want & mask))
         report_mismatch($sformatf("register %0d read %h, want %h", idx,
                                   csr_prdata & mask, want & mask));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input int kp, input int ig, input int dg,
                                input int olim, input int slim, input int sumlim);
      csr_write(REG_KP, kp);
      csr_write(REG_INT_GAIN, ig);
      csr_write(REG_DER_GAIN, dg);
      csr_write(REG_OUT_LIMIT, olim);
      csr_write(REG_STEP_LIMIT, slim);
      csr_write(REG_ACCUM_LIMIT, sumlim);
   endtask

   // leaves tvalid high on return so a back-to-back request keeps it up
   task automatic send_request(input logic [CMD_WIDTH-1:0] cmd,
                               input logic signed [SW-1:0] setpoint,
                               input logic signed [SW-1:0] measurement,
                               input logic signed [SW-1:0] feedforward);
      int gap;
      gap = req_no_gap ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {feedforward, measurement, setpoint};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      step_controller(cmd, setpoint, measurement, feedforward);
   endtask

   // drop the request line, let all responses arrive, then let the pipe empty
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_drive_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [SW-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7FFF;
               1:       return 16'sh8000;
               2:       return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         1, 2, 3: return SW'($urandom_range(0, 1023) - 512);
         default: return SW'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [CMD_WIDTH-1:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return CMD_TRACK;
      if (r < 90)
         return CMD_ERROR;
      if (r < 96)
         return CMD_CLEAR;
      return CMD_UNUSED;
   endfunction

   function automatic int pick_gain();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 65535);
      return $urandom_range(0, 2047) - 1024;
   endfunction

   task automatic test_register_access();
      logic [CSR_INDEX_WIDTH-1:0] idx;
      for (int i = 0; i < 6; i++) begin
         idx = CSR_INDEX_WIDTH'(i);
         csr_write(idx, 32'hFFFF_FFFF);
         csr_read_check(idx, 32'hFFFF_FFFF);
         csr_write(idx, 32'h0000_0000);
         csr_read_check(idx, 32'h0000_0000);
         csr_write(idx, 32'h0055_A5A5);
         csr_read_check(idx, 32'h0055_A5A5);
      end
   endtask

   task automatic test_directed();
      // unity gains, wide limits
      apply_setting(256, 4096, 256, 32767, 65535, 8388607);
      send_request(CMD_TRACK, 16'sh7FFF, 16'sh8000, 16'sh0000);   // error saturates high
      send_request(CMD_TRACK, 16'sh8000, 16'sh7FFF, 16'sh0000);   // error saturates low
      send_request(CMD_ERROR, 16'sh8000, 16'sh1234, 16'sh7FFF);
      send_request(CMD_ERROR, 16'sh7FFF, 16'shFFFF, 16'sh8000);
      send_request(CMD_TRACK, 16'sh0000, 16'sh0000, 16'sh0000);
      send_request(CMD_CLEAR, 16'sh5A5A, 16'shA5A5, 16'sh7FFF);
      send_request(CMD_ERROR, 16'sh0064, 16'sh0000, 16'sh0000);
      send_request(CMD_UNUSED, 16'sh7FFF, 16'sh8000, 16'shFFFF);
      send_request(CMD_ERROR, 16'sh1234, 16'shFFFF, 16'sh0000);
      // tight clamp and slew: drive ramps towards the limit
      wait_idle();
      csr_write(REG_OUT_LIMIT, 32'h0100);
      csr_write(REG_STEP_LIMIT, 32'h0040);
      repeat (4) send_request(CMD_ERROR, 16'sh7FFF, 16'sh0000, 16'sh0000);
      // clamp lowered under the last drive: slew keeps drive above the clamp
      wait_idle();
      csr_write(REG_OUT_LIMIT, 32'h0010);
      csr_write(REG_STEP_LIMIT, 32'h0020);
      repeat (3) send_request(CMD_ERROR, 16'sh7FFF, 16'sh0000, 16'sh0000);
      // sum limit lowered, zero slew: drive frozen
      wait_idle();
      csr_write(REG_ACCUM_LIMIT, 32'h0080);
      csr_write(REG_STEP_LIMIT, 32'h0000);
      repeat (2) send_request(CMD_ERROR, 16'sh8000, 16'sh0000, 16'sh7FFF);
      wait_idle();
   endtask

   task automatic test_random_phases();
      logic [CMD_WIDTH-1:0]   cmd;
      logic signed [SW-1:0]   setpoint;
      logic signed [SW-1:0]   measurement;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_setting(32767, 32767, 32767, 32767, 65535, 8388607);
            1: apply_setting(-32768, -32768, -32768, 32767, 65535, 8388607);
            2: apply_setting(0, 0, 0, 0, 0, 0);
            3: apply_setting(256, 41, 128, 'h2000, 'h0400, 'h10_0000);
            default: apply_setting(pick_gain(), pick_gain(), pick_gain(),
                                   $urandom_range(0, 32767), $urandom_range(0, 65535),
                                   $urandom_range(0, 8388607));
         endcase
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (n % 40 == 0) begin
               req_no_gap   = ($urandom_range(0, 3) == 0);
               rsp_no_stall = ($urandom_range(0, 3) == 0);
            end
            cmd      = pick_command();
            setpoint = pick_sample();
            // a third of the tracking requests sit close to the setpoint
            if (cmd == CMD_TRACK && $urandom_range(0, 2) == 0)
               measurement = SW'(setpoint + $urandom_range(0, 255) - 128);
            else
               measurement = pick_sample();
            send_request(cmd, setpoint, measurement, pick_sample());
         end
         wait_idle();
      end
   endtask

   // response side: random hold-off after each response, checked in order
   initial begin : response_check
      int stall;
      logic signed [SW-1:0] want;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_drive_q.size() == 0) begin
               report_mismatch($sformatf("response %h with no request outstanding",
                                         rsp_tdata));
            end else begin
               want = expected_drive_q.pop_front();
               if (rsp_tdata[SW-1:0] !== want)
                  report_mismatch($sformatf("drive %h, want %h", rsp_tdata[SW-1:0], want));
            end
            stall = rsp_no_stall ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_directed();
      test_random_phases();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
